FILE: hw/rtl/scl_pkg.sv
// ----------------------------------------------------------------------------
// scl_pkg
// Shared constants for the scalar colormap lookup: table geometry, register
// indexes and output format codes.
// ----------------------------------------------------------------------------
package scl_pkg;

    localparam int unsigned TABLE_DEPTH = 256;
    localparam int unsigned TABLE_AW    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    // configuration register indexes
    localparam logic [2:0] CFG_RANGE_LOW   = 3'd0;
    localparam logic [2:0] CFG_INDEX_SCALE = 3'd1;
    localparam logic [2:0] CFG_ALPHA_GAIN  = 3'd2;
    localparam logic [2:0] CFG_CLAMP       = 3'd3;
    localparam logic [2:0] CFG_INVERT      = 3'd4;
    localparam logic [2:0] CFG_FORMAT      = 3'd5;
    localparam logic [2:0] CFG_LEFT_COLOR  = 3'd6;
    localparam logic [2:0] CFG_RIGHT_COLOR = 3'd7;

    // output formats
    localparam logic [1:0] FMT_RGBA = 2'd0;
    localparam logic [1:0] FMT_RGB  = 2'd1;
    localparam logic [1:0] FMT_LA   = 2'd2;
    localparam logic [1:0] FMT_L    = 2'd3;

    // input kinds
    localparam logic ACT_MAP   = 1'b0;
    localparam logic ACT_WRITE = 1'b1;

    // floor(x / 100) for x below 25600 as (x * LUM_RECIP) >> LUM_SHIFT
    localparam logic [12:0] LUM_RECIP = 13'd5243;
    localparam int unsigned LUM_SHIFT = 19;

endpackage

FILE: hw/rtl/scalar_colormap_lookup.sv
// ----------------------------------------------------------------------------
// scalar_colormap_lookup
// Window/level mapping of signed samples through an RGBA color table.
// ----------------------------------------------------------------------------
// The block takes one transfer per clock unless output stalls back up to it,
// and keeps that rate under any mix of map and table-write items. A map
// result passes through all five register stages before it is offered;
// output stalls hold it longer. The five register stages are: offset
// subtract, Q16.16 scale multiply, range check with the registered table read,
// color select with luminance/alpha products, and the divide-by-100 reciprocal
// with format packing. Table writes use the same single memory port as the
// read, so they take effect in stream order. Table contents are undefined
// until written; write items give no output.
module scalar_colormap_lookup
    import scl_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    // input stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [55:0] i_s_axis_tdata,  // sample[15:0], entry_index[23:16], entry_color[55:24]
    input  logic        i_s_axis_tuser,  // action
    input  logic        i_s_axis_tlast,
    // output stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,  // chan0[7:0], chan1[15:8], chan2[23:16], chan3[31:24]
    output logic [2:0]  o_m_axis_tuser,  // byte_count
    output logic        o_m_axis_tlast
);

    localparam logic [48:0] POS_TOP = 49'(TABLE_DEPTH - 1) << 16;

    // configuration registers
    logic signed [15:0] r_range_low;
    logic [31:0]        r_index_scale;
    logic [8:0]         r_alpha_gain;
    logic               r_clamp;
    logic               r_invert;
    logic [1:0]         r_format;
    logic [31:0]        r_left_color;
    logic [31:0]        r_right_color;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_range_low   <= '0;
            r_index_scale <= 32'd65536;
            r_alpha_gain  <= 9'd256;
            r_clamp       <= 1'b0;
            r_invert      <= 1'b0;
            r_format      <= FMT_RGBA;
            r_left_color  <= '0;
            r_right_color <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_RANGE_LOW:   r_range_low   <= signed'(i_cfg_data[15:0]);
                CFG_INDEX_SCALE: r_index_scale <= i_cfg_data;
                CFG_ALPHA_GAIN:  r_alpha_gain  <= i_cfg_data[8:0];
                CFG_CLAMP:       r_clamp       <= i_cfg_data[0];
                CFG_INVERT:      r_invert      <= i_cfg_data[0];
                CFG_FORMAT:      r_format      <= i_cfg_data[1:0];
                CFG_LEFT_COLOR:  r_left_color  <= i_cfg_data;
                CFG_RIGHT_COLOR: r_right_color <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // stage valids and per-stage ready chain
    logic r_v1, r_v2, r_v3, r_v4, r_v5;
    logic rdy1, rdy2, rdy3, rdy4, rdy5;

    assign rdy5 = !r_v5 || i_m_axis_tready;
    assign rdy4 = !r_v4 || rdy5;
    assign rdy3 = !r_v3 || rdy4;
    assign rdy2 = !r_v2 || rdy3;
    assign rdy1 = !r_v1 || rdy2;
    assign o_s_axis_tready = rdy1;

    // stage 1: offset
    logic signed [16:0] r_s1_diff;
    logic               r_s1_action;
    logic [7:0]         r_s1_index;
    logic [31:0]        r_s1_color;
    logic               r_s1_last;

    // stage 2: scaled position
    logic signed [49:0] r_s2_prod;
    logic               r_s2_action;
    logic [7:0]         r_s2_index;
    logic [31:0]        r_s2_color;
    logic               r_s2_last;

    // stage 3: table word and range flags
    logic [31:0]        r_s3_rdata;
    logic               r_s3_use_table;
    logic               r_s3_neg;
    logic               r_s3_last;

    // stage 4: channel products
    logic [7:0]         r_s4_r, r_s4_g, r_s4_b, r_s4_a;
    logic [14:0]        r_s4_lum_sum;
    logic               r_s4_last;

    // stage 5: output
    logic [31:0]        r_s5_data;
    logic [2:0]         r_s5_count;
    logic               r_s5_last;

    // color table
    logic [31:0]        r_table [TABLE_DEPTH];

    // stage 2 position decode
    logic                neg2, over2;
    logic [TABLE_AW-1:0] pos2, addr2;
    logic                adv2;

    always_comb begin
        neg2  = r_s2_prod[49];
        over2 = !neg2 && (r_s2_prod[48:0] > POS_TOP);
        if (neg2) begin
            pos2 = '0;
        end else if (over2) begin
            pos2 = TABLE_AW'(TABLE_DEPTH - 1);
        end else begin
            pos2 = r_s2_prod[16 +: TABLE_AW];
        end
        addr2 = r_invert ? (TABLE_AW'(TABLE_DEPTH - 1) - pos2) : pos2;
    end

    assign adv2 = r_v2 && rdy3;

    // stage 3 color select and products
    logic [31:0] color3;
    logic [16:0] alpha_prod3;
    logic [7:0]  alpha3;

    always_comb begin
        if (r_s3_use_table) begin
            color3 = r_s3_rdata;
        end else if (r_s3_neg) begin
            color3 = r_left_color;
        end else begin
            color3 = r_right_color;
        end
        alpha_prod3 = 17'(color3[31:24]) * 17'(r_alpha_gain);
        // a gain of 256 or more passes alpha unchanged
        alpha3 = r_alpha_gain[8] ? color3[31:24] : alpha_prod3[15:8];
    end

    // stage 4 luminance and packing
    logic [27:0] lum_prod4;
    logic [7:0]  lum4;
    logic [31:0] data4;
    logic [2:0]  count4;

    always_comb begin
        lum_prod4 = 28'(r_s4_lum_sum) * 28'(LUM_RECIP);
        lum4      = lum_prod4[LUM_SHIFT +: 8];
        unique case (r_format)
            FMT_RGBA: begin
                data4  = {r_s4_a, r_s4_b, r_s4_g, r_s4_r};
                count4 = 3'd4;
            end
            FMT_RGB: begin
                data4  = {8'd0, r_s4_b, r_s4_g, r_s4_r};
                count4 = 3'd3;
            end
            FMT_LA: begin
                data4  = {16'd0, r_s4_a, lum4};
                count4 = 3'd2;
            end
            default: begin
                data4  = {24'd0, lum4};
                count4 = 3'd1;
            end
        endcase
    end

    // valid bits; write items leave the stream at the table stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            if (rdy1) r_v1 <= i_s_axis_tvalid;
            if (rdy2) r_v2 <= r_v1;
            if (rdy3) r_v3 <= r_v2 && (r_s2_action == ACT_MAP);
            if (rdy4) r_v4 <= r_v3;
            if (rdy5) r_v5 <= r_v4;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (rdy1) begin
            r_s1_diff   <= 17'(signed'(i_s_axis_tdata[15:0])) - 17'(r_range_low);
            r_s1_action <= i_s_axis_tuser;
            r_s1_index  <= i_s_axis_tdata[23:16];
            r_s1_color  <= i_s_axis_tdata[55:24];
            r_s1_last   <= i_s_axis_tlast;
        end
        if (rdy2) begin
            r_s2_prod   <= 50'(r_s1_diff) * 50'(signed'({1'b0, r_index_scale}));
            r_s2_action <= r_s1_action;
            r_s2_index  <= r_s1_index;
            r_s2_color  <= r_s1_color;
            r_s2_last   <= r_s1_last;
        end
        if (rdy3) begin
            r_s3_use_table <= r_clamp || !(neg2 || over2);
            r_s3_neg       <= neg2;
            r_s3_last      <= r_s2_last;
        end
        if (rdy4) begin
            r_s4_r       <= color3[7:0];
            r_s4_g       <= color3[15:8];
            r_s4_b       <= color3[23:16];
            r_s4_a       <= alpha3;
            r_s4_lum_sum <= 15'd30 * 15'(color3[7:0]) + 15'd59 * 15'(color3[15:8])
                          + 15'd11 * 15'(color3[23:16]) + 15'd50;
            r_s4_last    <= r_s3_last;
        end
        if (rdy5) begin
            r_s5_data  <= data4;
            r_s5_count <= count4;
            r_s5_last  <= r_s4_last;
        end
    end

    // single port table: a write transfer stores, a map transfer reads
    always_ff @(posedge i_clk) begin
        if (adv2) begin
            if (r_s2_action == ACT_WRITE) begin
                if (32'(r_s2_index) < 32'(TABLE_DEPTH)) begin
                    r_table[TABLE_AW'(r_s2_index)] <= r_s2_color;
                end
            end else begin
                r_s3_rdata <= r_table[addr2];
            end
        end
    end

    assign o_m_axis_tvalid = r_v5;
    assign o_m_axis_tdata  = r_s5_data;
    assign o_m_axis_tuser  = r_s5_count;
    assign o_m_axis_tlast  = r_s5_last;

endmodule
